// File: rtl/bdq_pkg.sv
// bdq_pkg: shared types and constants for the bounded deque engine
`timescale 1ns / 1ps
package bdq_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int CAP_W     = 5;
  localparam int DEPTH_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_LEFT  = 2'd0,
    OP_PUSH_RIGHT = 2'd1,
    OP_POP_LEFT   = 2'd2,
    OP_POP_RIGHT  = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic rd_en;
    logic commit;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pop;
    logic ok;
  } dp_sts_t;

endpackage

// File: rtl/bdq_datapath.sv
// bdq_datapath: ring store, head and count registers, capacity register and result register
`timescale 1ns / 1ps
module bdq_datapath #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bdq_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic [bdq_pkg::OP_W-1:0]   req_type_i,
  input  logic [bdq_pkg::DATA_W-1:0] push_value_i,
  input  bdq_pkg::dp_cmd_t           cmd_i,
  output bdq_pkg::dp_sts_t           sts_o,
  output logic [bdq_pkg::OP_W-1:0]   done_op_o,
  output logic [bdq_pkg::ST_W-1:0]   status_o,
  output logic [bdq_pkg::DATA_W-1:0] item_value_o
);
  import bdq_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = AW + 1;
  localparam int CMPW = (CAP_W > CW) ? CAP_W : CW;
  localparam logic [SW-1:0]   DEPTH_S = SW'(DEPTH);
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);
  localparam logic [AW-1:0]   LAST_A  = AW'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;

  logic [CAP_W-1:0]  capacity_q;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  op_e               op_q;
  logic [DATA_W-1:0] val_q;

  logic [OP_W-1:0]   done_op_q;
  logic [ST_W-1:0]   status_q;
  logic [DATA_W-1:0] item_q;

  logic [CMPW-1:0] cap_ext, cap_eff;
  logic            is_push, full, empty, ok;
  logic [AW-1:0]   head_dec, head_inc, tail_push, tail_pop, addr;
  logic [SW-1:0]   sum_push, sum_pop;
  status_e         st_next;

  always_comb begin
    cap_ext = CMPW'(capacity_q);
    cap_eff = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
    is_push = !op_q[1];
    full    = CMPW'(count_q) >= cap_eff;
    empty   = count_q == '0;
    ok      = is_push ? !full : !empty;
  end

  // ring positions left of head, right of head, and at either tail
  always_comb begin
    head_dec  = (head_q == '0) ? LAST_A : head_q - AW'(1);
    head_inc  = (head_q == LAST_A) ? '0 : head_q + AW'(1);
    sum_push  = SW'(head_q) + SW'(count_q);
    sum_pop   = sum_push - SW'(1);
    tail_push = (sum_push >= DEPTH_S) ? AW'(sum_push - DEPTH_S) : AW'(sum_push);
    tail_pop  = (sum_pop >= DEPTH_S) ? AW'(sum_pop - DEPTH_S) : AW'(sum_pop);
  end

  always_comb begin
    case (op_q)
      OP_PUSH_LEFT:  addr = head_dec;
      OP_PUSH_RIGHT: addr = tail_push;
      OP_POP_LEFT:   addr = head_q;
      OP_POP_RIGHT:  addr = tail_pop;
      default:       addr = head_q;
    endcase
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.commit && ok) begin
      case (op_q)
        OP_PUSH_LEFT: begin
          head_d  = head_dec;
          count_d = count_q + CW'(1);
        end
        OP_PUSH_RIGHT: count_d = count_q + CW'(1);
        OP_POP_LEFT: begin
          head_d  = head_inc;
          count_d = count_q - CW'(1);
        end
        OP_POP_RIGHT: count_d = count_q - CW'(1);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ok) begin
      st_next = ST_OK;
    end else if (is_push) begin
      st_next = ST_FULL;
    end else begin
      st_next = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
      head_q     <= '0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= op_e'(req_type_i);
      val_q <= push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ok && is_push) begin
      mem[addr] <= val_q;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      done_op_q <= op_q;
      status_q  <= st_next;
      if (!ok) begin
        item_q <= '0;
      end else if (is_push) begin
        item_q <= val_q;
      end else begin
        item_q <= rd_q;
      end
    end
  end

  assign sts_o.is_pop  = !is_push;
  assign sts_o.ok      = ok;
  assign done_op_o     = done_op_q;
  assign status_o      = status_q;
  assign item_value_o  = item_q;

endmodule

// File: rtl/bdq_ctrl.sv
// bdq_ctrl: request sequencing and output word valid
`timescale 1ns / 1ps
module bdq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bdq_pkg::dp_cmd_t cmd_o,
  input  bdq_pkg::dp_sts_t sts_i
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free, pop_ok;

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    pop_ok   = sts_i.is_pop && sts_i.ok;
    cmd_o    = '0;
    state_d  = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (pop_ok) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_READ;
        end else if (out_free) begin
          cmd_o.commit   = 1'b1;
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_READ: begin
        // read data holds until the output slot frees up
        if (out_free) begin
          cmd_o.commit   = 1'b1;
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/bounded_deque_engine.sv
// bounded_deque_engine: top level of the bounded double-ended queue
//
//   channel   direction  handshake               payload
//   request   in         in_valid_i / in_ready_o  req_type_i, push_value_i
//   result    out        out_valid_o/out_ready_i  done_op_o, status_o, item_value_o
//   config    in         cfg_we_i                 cfg_wdata_i (capacity)
//
// a push or a refused request is latched in idle and its result is loaded in
// the exec step; a pop that succeeds adds a read step for the registered read
// of the single-port ring memory. one request is in flight at a time; the next
// word is taken as soon as the result is loaded, even if it is not yet taken.
// a stalled result holds the sequencer in its last step. reset clears head,
// count and capacity (to 16) at once; the ring is not cleared.
`timescale 1ns / 1ps
module bounded_deque_engine #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bdq_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [bdq_pkg::OP_W-1:0]   req_type_i,
  input  logic [bdq_pkg::DATA_W-1:0] push_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bdq_pkg::OP_W-1:0]   done_op_o,
  output logic [bdq_pkg::ST_W-1:0]   status_o,
  output logic [bdq_pkg::DATA_W-1:0] item_value_o
);
  import bdq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_type_i),
    .push_value_i (push_value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .done_op_o    (done_op_o),
    .status_o     (status_o),
    .item_value_o (item_value_o)
  );

endmodule

// File: rtl/bdq_chk.sv
// bdq_chk: port-level assertions for the bounded deque engine, bound to the top level
`timescale 1ns / 1ps
module bdq_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [bdq_pkg::OP_W-1:0]   done_op_o,
  input logic [bdq_pkg::ST_W-1:0]   status_o,
  input logic [bdq_pkg::DATA_W-1:0] item_value_o
);
  import bdq_pkg::*;

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(done_op_o) && $stable(item_value_o))
    else $error("result word changed while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_FULL || status_o == ST_EMPTY))
    else $error("bad status code");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> item_value_o == '0)
    else $error("nonzero value on refused request");

  // full only answers pushes, empty only answers pops
  a_status_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != ST_FULL || !done_op_o[1])
      && (status_o != ST_EMPTY || done_op_o[1]))
    else $error("status does not match operation");

endmodule

bind bounded_deque_engine bdq_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .done_op_o    (done_op_o),
  .status_o     (status_o),
  .item_value_o (item_value_o)
);
